// ----- src/pbt_pkg.sv -----
// ----------------------------------------------------------------------------
// pbt_pkg: shared types and constants of the polyomino boundary tracer
// Direction codes, trace state, result item and register map.
// ----------------------------------------------------------------------------
package pbt_pkg;

  // edge direction codes
  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  // coordinate and register widths
  localparam int unsigned CoordW = 4;
  localparam int unsigned DimW   = 4;
  localparam int unsigned OccW   = 64;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 64;

  // register indexes, 8-byte spacing (index is paddr[4:3])
  localparam logic [1:0] RegGridWidth  = 2'd0;
  localparam logic [1:0] RegGridHeight = 2'd1;
  localparam logic [1:0] RegOccupancy  = 2'd2;

  // register reset values
  localparam logic [DimW-1:0] GridDimReset = 4'd8;

  // corner the trace stands on between steps
  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    dir_e              heading;
    logic              at_start;
  } pbt_state_t;

  // one result item
  typedef struct packed {
    logic [CoordW-1:0] from_x;
    logic [CoordW-1:0] from_y;
    logic [CoordW-1:0] to_x;
    logic [CoordW-1:0] to_y;
    dir_e              heading;
    logic              closes_loop;
    logic              no_shape;
  } pbt_item_t;

endpackage

// ----- src/pbt_step.sv -----
// ----------------------------------------------------------------------------
// pbt_step: next boundary edge
// Finds the start corner, looks at the four cells around the current corner
// and picks the first outgoing edge turning right from the last heading.
// ----------------------------------------------------------------------------
module pbt_step #(
  parameter int unsigned GRID_SIDE = 8
) (
  input  logic [pbt_pkg::DimW-1:0]        grid_width_i,
  input  logic [pbt_pkg::DimW-1:0]        grid_height_i,
  input  logic [GRID_SIDE*GRID_SIDE-1:0]  occupancy_i,
  input  pbt_pkg::pbt_state_t             state_i,
  input  logic                            restart_i,
  output pbt_pkg::pbt_item_t              item_o,
  output pbt_pkg::pbt_state_t             state_o
);
  import pbt_pkg::*;

  localparam int unsigned IdxW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;

  // cells in use, masked by the active width and height
  logic [GRID_SIDE-1:0][GRID_SIDE-1:0] cell_grid;

  for (genvar gy = 0; gy < GRID_SIDE; gy++) begin : g_row
    for (genvar gx = 0; gx < GRID_SIDE; gx++) begin : g_col
      assign cell_grid[gy][gx] = occupancy_i[gy*GRID_SIDE + gx]
                                 && (DimW'(gx) < grid_width_i)
                                 && (DimW'(gy) < grid_height_i);
    end
  end

  // cell lookup with signed coordinates, outside the grid reads empty
  function automatic logic cell_on(input logic [GRID_SIDE-1:0][GRID_SIDE-1:0] grid,
                                   input logic [CoordW:0] x,
                                   input logic [CoordW:0] y);
    logic in_range;
    in_range = !x[CoordW] && !y[CoordW]
               && (x[CoordW-1:0] < CoordW'(GRID_SIDE))
               && (y[CoordW-1:0] < CoordW'(GRID_SIDE));
    return in_range ? grid[y[IdxW-1:0]][x[IdxW-1:0]] : 1'b0;
  endfunction

  // leftmost filled cell of the top row
  logic              start_found;
  logic [CoordW-1:0] start_x;

  always_comb begin
    start_found = 1'b0;
    start_x     = '0;
    for (int i = 0; i < GRID_SIDE; i++) begin
      if (!start_found && cell_grid[0][i]) begin
        start_found = 1'b1;
        start_x     = CoordW'(i);
      end
    end
  end

  // corner to work from this step
  logic              go_start;
  logic [CoordW-1:0] cur_col;
  logic [CoordW-1:0] cur_row;
  dir_e              base_dir;

  assign go_start = restart_i || state_i.at_start;
  assign cur_col  = go_start ? start_x : state_i.col;
  assign cur_row  = go_start ? '0 : state_i.row;
  assign base_dir = go_start ? DIR_UP : state_i.heading;

  // the four cells around the corner
  logic [CoordW:0] cx;
  logic [CoordW:0] cy;
  logic [CoordW:0] cxm;
  logic [CoordW:0] cym;
  logic            c_se, c_ne, c_sw, c_nw;
  logic [3:0]      edge_ok;

  assign cx   = {1'b0, cur_col};
  assign cy   = {1'b0, cur_row};
  assign cxm  = cx - (CoordW+1)'(1);
  assign cym  = cy - (CoordW+1)'(1);
  assign c_se = cell_on(cell_grid, cx,  cy);
  assign c_ne = cell_on(cell_grid, cx,  cym);
  assign c_sw = cell_on(cell_grid, cxm, cy);
  assign c_nw = cell_on(cell_grid, cxm, cym);

  // filled cell on the right-hand side of travel
  assign edge_ok[DIR_RIGHT] = c_se && !c_ne;
  assign edge_ok[DIR_DOWN]  = c_sw && !c_se;
  assign edge_ok[DIR_LEFT]  = c_nw && !c_sw;
  assign edge_ok[DIR_UP]    = c_ne && !c_nw;

  // try prev+1 .. prev+4 in order
  logic edge_found;
  dir_e pick_dir;
  dir_e cand_dir;

  always_comb begin
    edge_found = 1'b0;
    pick_dir   = DIR_RIGHT;
    cand_dir   = DIR_RIGHT;
    for (int k = 1; k <= 4; k++) begin
      cand_dir = dir_e'(base_dir + 2'(k));
      if (!edge_found && edge_ok[cand_dir]) begin
        edge_found = 1'b1;
        pick_dir   = cand_dir;
      end
    end
  end

  // dead corner falls back to the start corner heading right
  logic [CoordW-1:0] from_col;
  logic [CoordW-1:0] from_row;
  dir_e              step_dir;
  logic [CoordW-1:0] to_col;
  logic [CoordW-1:0] to_row;
  logic              closes;

  assign from_col = edge_found ? cur_col : start_x;
  assign from_row = edge_found ? cur_row : '0;
  assign step_dir = edge_found ? pick_dir : DIR_RIGHT;

  always_comb begin
    to_col = from_col;
    to_row = from_row;
    unique case (step_dir)
      DIR_RIGHT: to_col = from_col + CoordW'(1);
      DIR_DOWN:  to_row = from_row + CoordW'(1);
      DIR_LEFT:  to_col = from_col - CoordW'(1);
      DIR_UP:    to_row = from_row - CoordW'(1);
      default:   to_col = from_col;
    endcase
  end

  assign closes = (to_col == start_x) && (to_row == '0);

  // result and next state
  always_comb begin
    if (!start_found) begin
      item_o          = '0;
      item_o.no_shape = 1'b1;
      state_o          = state_i;
      state_o.at_start = 1'b1;
    end else begin
      item_o.from_x      = from_col;
      item_o.from_y      = from_row;
      item_o.to_x        = to_col;
      item_o.to_y        = to_row;
      item_o.heading     = step_dir;
      item_o.closes_loop = closes;
      item_o.no_shape    = 1'b0;
      state_o.col      = to_col;
      state_o.row      = to_row;
      state_o.heading  = step_dir;
      state_o.at_start = closes;
    end
  end

endmodule

// ----- src/pbt_out_buf.sv -----
// ----------------------------------------------------------------------------
// pbt_out_buf: result register with skid stage
// Holds results for the output channel; stall to the producer is registered.
// ----------------------------------------------------------------------------
module pbt_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  input  pbt_pkg::pbt_item_t push_item_i,
  output logic               push_stall_o,
  output logic               out_valid_o,
  output pbt_pkg::pbt_item_t out_item_o,
  input  logic               out_stall_i
);
  import pbt_pkg::*;

  logic      main_valid_q;
  logic      skid_valid_q;
  pbt_item_t main_q;
  pbt_item_t skid_q;
  logic      push;
  logic      pop;

  assign push_stall_o = skid_valid_q;
  assign push         = push_valid_i && !skid_valid_q;
  assign pop          = main_valid_q && !out_stall_i;
  assign out_valid_o  = main_valid_q;
  assign out_item_o   = main_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (pop && skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (pop) begin
        main_valid_q <= push;
      end else if (push && main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else if (push) begin
        main_valid_q <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    priority if (pop && skid_valid_q) begin
      main_q <= skid_q;
    end else if (push && (pop || !main_valid_q)) begin
      main_q <= push_item_i;
    end else if (push) begin
      skid_q <= push_item_i;
    end
  end

endmodule

// ----- src/polyomino_boundary_tracer.sv -----
// ----------------------------------------------------------------------------
// polyomino_boundary_tracer: outer contour tracing of a cell mask
// Each step transfer yields the next unit edge of the shape's boundary, or a no-shape flag when the top row is empty.
// ----------------------------------------------------------------------------
// A result is registered in the output buffer when its step transfer is accepted.
// Throughput: one step per cycle while the input is not stalled.
// The two-entry output buffer stalls the input only when both entries are full.
// Reset: grid 8 by 8, empty mask, trace at the start corner heading up,
// output buffer empty.
module polyomino_boundary_tracer #(
  parameter int unsigned GRID_SIDE = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbt_pkg::AddrW-1:0]    paddr,
  input  logic [pbt_pkg::DataW-1:0]    pwdata,
  output logic [pbt_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  // step channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         restart_i,
  // edge channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pbt_pkg::CoordW-1:0]   from_x_o,
  output logic [pbt_pkg::CoordW-1:0]   from_y_o,
  output logic [pbt_pkg::CoordW-1:0]   to_x_o,
  output logic [pbt_pkg::CoordW-1:0]   to_y_o,
  output logic [1:0]                   heading_o,
  output logic                         closes_loop_o,
  output logic                         no_shape_o
);
  import pbt_pkg::*;

  localparam int unsigned Cells = GRID_SIDE * GRID_SIDE;

  // configuration registers
  logic [DimW-1:0] grid_width_q;
  logic [DimW-1:0] grid_height_q;
  logic [OccW-1:0] occupancy_q;
  logic            cfg_write;
  logic [1:0]      reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[AddrW-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GridDimReset;
      grid_height_q <= GridDimReset;
      occupancy_q   <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        RegGridWidth:  grid_width_q  <= pwdata[DimW-1:0];
        RegGridHeight: grid_height_q <= pwdata[DimW-1:0];
        RegOccupancy:  occupancy_q   <= pwdata;
        default:       ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      RegGridWidth:  prdata = DataW'(grid_width_q);
      RegGridHeight: prdata = DataW'(grid_height_q);
      RegOccupancy:  prdata = occupancy_q;
      default:       prdata = '0;
    endcase
  end

  // trace step
  pbt_state_t state_q;
  pbt_state_t state_d;
  pbt_item_t  step_item;
  pbt_item_t  out_item;
  logic       in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  pbt_step #(
    .GRID_SIDE (GRID_SIDE)
  ) u_step (
    .grid_width_i  (grid_width_q),
    .grid_height_i (grid_height_q),
    .occupancy_i   (occupancy_q[Cells-1:0]),
    .state_i       (state_q),
    .restart_i     (restart_i),
    .item_o        (step_item),
    .state_o       (state_d)
  );

  // trace state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.col      <= '0;
      state_q.row      <= '0;
      state_q.heading  <= DIR_UP;
      state_q.at_start <= 1'b1;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // result buffer
  pbt_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_item_i  (step_item),
    .push_stall_o (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item),
    .out_stall_i  (out_stall_i)
  );

  assign from_x_o      = out_item.from_x;
  assign from_y_o      = out_item.from_y;
  assign to_x_o        = out_item.to_x;
  assign to_y_o        = out_item.to_y;
  assign heading_o     = out_item.heading;
  assign closes_loop_o = out_item.closes_loop;
  assign no_shape_o    = out_item.no_shape;

endmodule

// ----- verif/polyomino_boundary_tracer_checker.sv -----
// ----------------------------------------------------------------------------
// polyomino_boundary_tracer_checker: edge predictor and scoreboard
// Follows register writes, checks register reads on the configuration port and keeps
// its own copy of the trace state. Each step transfer queues the predicted edge, and
// each edge transfer is compared field by field against the oldest queued edge.
// ----------------------------------------------------------------------------
module polyomino_boundary_tracer_checker #(
  parameter int unsigned GRID_SIDE = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pbt_pkg::AddrW-1:0]       paddr,
  input  logic [pbt_pkg::DataW-1:0]       pwdata,
  input  logic [pbt_pkg::DataW-1:0]       prdata,
  input  logic                            pready,
  // step channel
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            restart_i,
  // edge channel
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [pbt_pkg::CoordW-1:0]      from_x_i,
  input  logic [pbt_pkg::CoordW-1:0]      from_y_i,
  input  logic [pbt_pkg::CoordW-1:0]      to_x_i,
  input  logic [pbt_pkg::CoordW-1:0]      to_y_i,
  input  logic [1:0]                      heading_i,
  input  logic                            closes_loop_i,
  input  logic                            no_shape_i,
  // status toward the testbench top
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  import pbt_pkg::*;

  // register copies
  logic [DimW-1:0]   grid_w;
  logic [DimW-1:0]   grid_h;
  logic [OccW-1:0]   occ;

  // trace position between steps
  logic [CoordW-1:0] trace_col;
  logic [CoordW-1:0] trace_row;
  dir_e              trace_dir;
  logic              trace_at_start;

  pbt_item_t         pending_edges[$];
  int unsigned       mismatches = 0;

  assign fail_count_o = mismatches;

  // dimensions above the grid side clamp to it
  function automatic int dim_in_use(logic [DimW-1:0] v);
    if (v > GRID_SIDE) return GRID_SIDE;
    return int'(v);
  endfunction

  // cells outside the grid in use read as empty
  function automatic logic cell_filled(int x, int y);
    if (x < 0 || y < 0 || x >= dim_in_use(grid_w) || y >= dim_in_use(grid_h)) return 1'b0;
    return occ[y * GRID_SIDE + x];
  endfunction

  // a boundary edge keeps the filled cell on its right
  function automatic logic edge_open(int cx, int cy, dir_e d);
    case (d)
      DIR_RIGHT: return cell_filled(cx, cy) && !cell_filled(cx, cy - 1);
      DIR_DOWN:  return cell_filled(cx - 1, cy) && !cell_filled(cx, cy);
      DIR_LEFT:  return cell_filled(cx - 1, cy - 1) && !cell_filled(cx - 1, cy);
      default:   return cell_filled(cx, cy - 1) && !cell_filled(cx - 1, cy - 1);
    endcase
  endfunction

  // predict the next boundary edge and advance the trace
  function automatic pbt_item_t next_edge(logic restart);
    int        x;
    int        k;
    int        first_col;
    int        cx;
    int        cy;
    int        nx;
    int        ny;
    logic [1:0] turn;
    dir_e      d;
    logic      found;
    pbt_item_t r;
    first_col = -1;
    for (x = GRID_SIDE - 1; x >= 0; x--) begin
      if (cell_filled(x, 0)) first_col = x;
    end
    r = '0;
    // nothing in the top row: flag only, trace will begin at the start corner
    if (first_col < 0) begin
      r.no_shape = 1'b1;
      trace_at_start = 1'b1;
      return r;
    end
    if (restart || trace_at_start) begin
      trace_col = first_col[CoordW-1:0];
      trace_row = '0;
      trace_dir = DIR_UP;
    end
    cx = int'(trace_col);
    cy = int'(trace_row);
    found = 1'b0;
    d = DIR_RIGHT;
    for (k = 1; k <= 4 && !found; k++) begin
      turn = trace_dir + k[1:0];
      d = dir_e'(turn);
      found = edge_open(cx, cy, d);
    end
    // dead corner: go back to the start corner, which always leads right
    if (!found) begin
      cx = first_col;
      cy = 0;
      d = DIR_RIGHT;
    end
    nx = cx + ((d == DIR_RIGHT) ? 1 : 0) - ((d == DIR_LEFT) ? 1 : 0);
    ny = cy + ((d == DIR_DOWN) ? 1 : 0) - ((d == DIR_UP) ? 1 : 0);
    r.from_x = cx[CoordW-1:0];
    r.from_y = cy[CoordW-1:0];
    r.to_x = nx[CoordW-1:0];
    r.to_y = ny[CoordW-1:0];
    r.heading = d;
    r.closes_loop = (nx == first_col) && (ny == 0);
    trace_col = nx[CoordW-1:0];
    trace_row = ny[CoordW-1:0];
    trace_dir = d;
    trace_at_start = r.closes_loop;
    return r;
  endfunction

  function automatic void check_field(string field, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  // watch the configuration port and both channels
  always @(posedge clk_i or negedge rst_ni) begin
    pbt_item_t want;
    if (!rst_ni) begin
      grid_w = GridDimReset;
      grid_h = GridDimReset;
      occ = '0;
      trace_col = '0;
      trace_row = '0;
      trace_dir = DIR_UP;
      trace_at_start = 1'b1;
      pending_edges.delete();
      pending_o <= 0;
    end else begin
      // register transfer
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[AddrW-1:3])
            RegGridWidth:  grid_w = pwdata[DimW-1:0];
            RegGridHeight: grid_h = pwdata[DimW-1:0];
            RegOccupancy:  occ = pwdata[OccW-1:0];
            default: ;
          endcase
        end else begin
          case (paddr[AddrW-1:3])
            RegGridWidth:  check_field("grid_width", grid_w, prdata[DimW-1:0]);
            RegGridHeight: check_field("grid_height", grid_h, prdata[DimW-1:0]);
            RegOccupancy:  check_field("occupancy", occ, prdata[OccW-1:0]);
            default: ;
          endcase
        end
      end
      // step transfer
      if (in_valid_i && !in_stall_i) pending_edges.push_back(next_edge(restart_i));
      // edge transfer
      if (out_valid_i && !out_stall_i) begin
        if (pending_edges.size() == 0) begin
          $error("edge transfer with no step outstanding");
          mismatches++;
        end else begin
          want = pending_edges.pop_front();
          check_field("from_x", want.from_x, from_x_i);
          check_field("from_y", want.from_y, from_y_i);
          check_field("to_x", want.to_x, to_x_i);
          check_field("to_y", want.to_y, to_y_i);
          check_field("heading", want.heading, heading_i);
          check_field("closes_loop", want.closes_loop, closes_loop_i);
          check_field("no_shape", want.no_shape, no_shape_i);
        end
      end
      pending_o <= pending_edges.size();
    end
  end

endmodule

// ----- verif/polyomino_boundary_tracer_tb.sv -----
// ----------------------------------------------------------------------------
// polyomino_boundary_tracer_tb: testbench top of the boundary tracer
// Programs grids and masks over the configuration port, sends step transfers
// in random bursts against a randomly stalling receiver, and leaves all
// prediction and comparison to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module polyomino_boundary_tracer_tb;
  import pbt_pkg::*;

  localparam int unsigned GridSide    = 8;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned StallLimit  = 4000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrW-1:0]     paddr;
  logic [DataW-1:0]     pwdata;
  logic [DataW-1:0]     prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 restart_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CoordW-1:0]    from_x_o;
  logic [CoordW-1:0]    from_y_o;
  logic [CoordW-1:0]    to_x_o;
  logic [CoordW-1:0]    to_y_o;
  logic [1:0]           heading_o;
  logic                 closes_loop_o;
  logic                 no_shape_o;

  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          idle_cycles = 0;
  int                   hold_seq = 0;
  logic [DimW-1:0]      cur_w;
  logic [DimW-1:0]      cur_h;

  polyomino_boundary_tracer #(
    .GRID_SIDE(GridSide)
  ) dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .restart_i,
    .out_valid_o, .out_stall_i,
    .from_x_o, .from_y_o, .to_x_o, .to_y_o, .heading_o, .closes_loop_o, .no_shape_o
  );

  polyomino_boundary_tracer_checker #(
    .GRID_SIDE(GridSide)
  ) u_checker (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_i(in_stall_o), .restart_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .from_x_i(from_x_o), .from_y_i(from_y_o), .to_x_i(to_x_o), .to_y_i(to_y_o),
    .heading_i(heading_o), .closes_loop_i(closes_loop_o), .no_shape_i(no_shape_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("polyomino_boundary_tracer_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int seg_left;
    int mode;
    int hold_seen;
    seg_left = 0;
    mode = 0;
    hold_seen = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 150);
        end
        seg_left--;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [DataW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_read(input logic [1:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_back();
    reg_read(RegGridWidth);
    reg_read(RegGridHeight);
    reg_read(RegOccupancy);
  endtask

  // hold one step transfer until accepted, valid stays up on return
  task automatic offer_step(input logic rs);
    in_valid_i <= 1'b1;
    restart_i <= rs;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    restart_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // registers change only once every edge is back
  task automatic settle();
    wait_drained();
    repeat (2) @(posedge clk_i);
  endtask

  // random bursts with gaps, or one unbroken stream when steady
  task automatic send_steps(input int n, input bit steady);
    int burst;
    int gap;
    while (n > 0) begin
      burst = steady ? n : $urandom_range(1, 12);
      if (burst > n) burst = n;
      repeat (burst) offer_step($urandom_range(0, 19) == 0);
      n -= burst;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (n == 0 || (!steady && gap > 0)) begin
        end_burst();
        if (n > 0) begin
          if ($urandom_range(0, 29) == 0) wait_drained();
          else repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  function automatic logic [DimW-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return DimW'($urandom_range(0, 15));
      1:       return DimW'(GridSide);
      default: return DimW'($urandom_range(1, GridSide));
    endcase
  endfunction

  // connected shape grown by a random walk from a top-row cell
  function automatic logic [OccW-1:0] grown_shape(logic [DimW-1:0] w, logic [DimW-1:0] h,
                                                  int cells);
    logic [OccW-1:0] m;
    int wl;
    int hl;
    int x;
    int y;
    int i;
    wl = (w == 0 || w > GridSide) ? GridSide : int'(w);
    hl = (h == 0 || h > GridSide) ? GridSide : int'(h);
    x = $urandom_range(0, wl - 1);
    y = 0;
    m = '0;
    m[x] = 1'b1;
    for (i = 0; i < cells; i++) begin
      case ($urandom_range(0, 3))
        0:       if (x < wl - 1) x++;
        1:       if (y < hl - 1) y++;
        2:       if (x > 0) x--;
        default: if (y > 0) y--;
      endcase
      m[y * GridSide + x] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [OccW-1:0] pick_mask(logic [DimW-1:0] w, logic [DimW-1:0] h);
    int kind;
    kind = $urandom_range(0, 19);
    if (kind <= 10) return grown_shape(w, h, $urandom_range(0, 40));
    if (kind <= 13) return {$urandom, $urandom} | {$urandom, $urandom};
    if (kind <= 15) return {$urandom, $urandom} & ~64'hFF;
    return {$urandom, $urandom};
  endfunction

  // stimulus
  initial begin
    int sent;
    int phase;
    int n;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    restart_i = 1'b0;
    cur_w = GridDimReset;
    cur_h = GridDimReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, empty mask gives no shape
    read_back();
    offer_step(1'b0);
    offer_step(1'b1);
    end_burst();
    settle();

    // single corner cell: a closed loop around the cell, then a fresh start
    reg_write(RegOccupancy, 64'h1);
    repeat (5) offer_step(1'b0);
    end_burst();
    settle();

    // oversized grid with a full mask, then a restart mid-trace
    reg_write(RegGridWidth, 64'hF);
    reg_write(RegGridHeight, 64'hF);
    reg_write(RegOccupancy, '1);
    read_back();
    repeat (6) offer_step(1'b0);
    offer_step(1'b1);
    end_burst();
    settle();

    // mask changes under the trace and leaves it on a dead corner
    reg_write(RegOccupancy, 64'h80);
    repeat (2) offer_step(1'b0);
    end_burst();
    settle();

    // zero width leaves no cell in use
    reg_write(RegGridWidth, 64'h0);
    offer_step(1'b0);
    end_burst();
    settle();

    // empty top row over a filled area
    reg_write(RegGridWidth, 64'h8);
    reg_write(RegOccupancy, 64'hFFFF_FFFF_FFFF_FF00);
    offer_step(1'b0);
    end_burst();
    settle();

    // one-by-one grid
    reg_write(RegGridWidth, 64'h1);
    reg_write(RegGridHeight, 64'h1);
    reg_write(RegOccupancy, '1);
    repeat (4) offer_step(1'b0);
    end_burst();
    cur_w = 4'd1;
    cur_h = 4'd1;

    // random phases, trace state carries over across register changes
    sent = 0;
    phase = 0;
    while (sent < RandomItems) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        cur_w = pick_dim();
        reg_write(RegGridWidth, DataW'(cur_w));
      end
      if ($urandom_range(0, 3) != 0) begin
        cur_h = pick_dim();
        reg_write(RegGridHeight, DataW'(cur_h));
      end
      if ($urandom_range(0, 7) != 0) reg_write(RegOccupancy, pick_mask(cur_w, cur_h));
      if ($urandom_range(0, 3) == 0) read_back();
      if (phase == 3 || phase == 20) begin
        // receiver holds off while steps keep coming, filling the block
        n = 40;
        hold_seq++;
        send_steps(n, 1'b1);
      end else begin
        n = $urandom_range(10, 60);
        send_steps(n, $urandom_range(0, 4) == 0);
      end
      sent += n;
      phase++;
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("polyomino_boundary_tracer_tb: clean");
    end else begin
      $display("polyomino_boundary_tracer_tb: errors");
    end
    $finish;
  end

endmodule
